// ===== rtl/rc4_multipass_keystream_cipher_core_assert.svh =====
// assertion macros shared by the cipher core rtl
`ifndef RC4_MULTIPASS_KEYSTREAM_CIPHER_CORE_ASSERT_SVH
`define RC4_MULTIPASS_KEYSTREAM_CIPHER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RC4_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rc4_pkg.sv =====
// shared types and constants of the rc4 cipher core
package rc4_pkg;

   localparam int KEY_BYTES_MAX = 256;
   localparam int KEY_IDX_W     = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
   localparam int KEY_CNT_W     = 9;
   localparam int SBOX_DEPTH    = 256;
   localparam int SBOX_AW       = $clog2(SBOX_DEPTH);
   localparam int BYTE_W        = 8;

   localparam logic [BYTE_W-1:0] PASSES_RESET = 8'd20;

   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] in_byte;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_last;
   } rsp_type;

endpackage

// ===== rtl/rc4_ram.sv =====
// generic single write, single read ram with registered read data
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rc4_multipass_keystream_cipher_core.sv =====
// rc4 cipher core with repeated key schedule, one shared sbox ram
//
//   channel  dir  handshake         payload
//   req      in   req_valid/stall   req_type  (cmd, in_byte, last)
//   rsp      out  rsp_valid/stall   rsp_type  (out_byte, out_last)
//   csr      in   csr_wr_en         csr_wr_data = schedule_passes
//
// a key byte is stored while idle; the last key byte starts an identity sweep
// of the sbox and then schedule_passes passes of key scheduling over it
// a data byte runs read i, read j, write i, write j with keystream read and
// output load on the one sbox ram, and waits to load while rsp is stalled
// after reset the sbox ram is swept to the identity, req stalled
// req_stall is high whenever the sequencer is not idle
// the result register holds its transfer while rsp_stall is high
module rc4_multipass_keystream_cipher_core
   import rc4_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload,
   input  logic              csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data
);

`include "rc4_multipass_keystream_cipher_core_assert.svh"

   typedef enum logic [3:0] {
      ST_INIT,   // identity sweep of the sbox
      ST_IDLE,   // waiting for a transfer, i+1 read issued
      ST_DJ,     // data: j += S[i], read S[j]
      ST_DWI,    // data: S[i] <= S[j], read S[S[i]+S[j]]
      ST_DWJ,    // data: S[j] <= S[i], keystream byte ready
      ST_EMIT,   // data: load result register
      ST_KRD,    // schedule: read S[n] and key[k]
      ST_KJ,     // schedule: j += S[n] + key[k], read S[j]
      ST_KWN,    // schedule: S[n] <= S[j]
      ST_KWJ     // schedule: S[j] <= S[n], advance n, k, pass
   } state_type;

   state_type             state_ff,     state_in;
   logic [SBOX_AW-1:0]    n_ff,         n_in;
   logic [BYTE_W-1:0]     i_ff,         i_in;
   logic [BYTE_W-1:0]     j_ff,         j_in;
   logic [BYTE_W-1:0]     si_ff,        si_in;
   logic [BYTE_W-1:0]     sj_ff,        sj_in;
   logic [BYTE_W-1:0]     t_ff,         t_in;
   logic [KEY_IDX_W-1:0]  k_ff,         k_in;
   logic [BYTE_W-1:0]     pass_ff,      pass_in;
   logic [KEY_CNT_W-1:0]  key_count_ff, key_count_in;
   logic [KEY_CNT_W-1:0]  key_len_ff,   key_len_in;
   logic                  sched_ff,     sched_in;
   logic [BYTE_W-1:0]     passes_ff,    passes_in;
   logic [BYTE_W-1:0]     ks_ff,        ks_in;
   logic [BYTE_W-1:0]     msg_ff,       msg_in;
   logic                  last_ff,      last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff,  rsp_data_in;

   // sbox and key ram ports
   logic                  perm_we;
   logic [SBOX_AW-1:0]    perm_wr_addr;
   logic [BYTE_W-1:0]     perm_wr_data;
   logic [SBOX_AW-1:0]    perm_rd_addr;
   logic [BYTE_W-1:0]     perm_rd;
   logic                  key_we;
   logic [BYTE_W-1:0]     key_rd;

   logic                  req_xfer;
   logic                  out_free;
   logic [BYTE_W-1:0]     add_out;
   logic [BYTE_W-1:0]     t_sum;
   logic [KEY_CNT_W-1:0]  k_next;

   assign req_xfer = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // the shared adder: j + S[x] (+ key byte while scheduling)
   assign add_out = j_ff + perm_rd + ((state_ff == ST_KJ) ? key_rd : '0);
   assign t_sum   = si_ff + perm_rd;
   assign k_next  = KEY_CNT_W'(k_ff) + KEY_CNT_W'(1);

   assign key_we = req_xfer && (req_payload.cmd == CMD_KEY) &&
                   (key_count_ff < KEY_CNT_W'(KEY_BYTES_MAX));

   rc4_ram #(.WIDTH(BYTE_W), .DEPTH(SBOX_DEPTH)) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_we),
      .wr_addr (perm_wr_addr),
      .wr_data (perm_wr_data),
      .rd_addr (perm_rd_addr),
      .rd_data (perm_rd)
   );

   rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_BYTES_MAX)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_count_ff[KEY_IDX_W-1:0]),
      .wr_data (req_payload.in_byte),
      .rd_addr (k_ff),
      .rd_data (key_rd)
   );

   // sbox port steering per sequencer step
   always_comb begin
      perm_we      = 1'b0;
      perm_wr_addr = n_ff;
      perm_wr_data = si_ff;
      perm_rd_addr = n_ff;
      case (state_ff)
         ST_INIT: begin
            perm_we      = 1'b1;
            perm_wr_data = BYTE_W'(n_ff);
         end
         ST_IDLE: begin
            perm_rd_addr = SBOX_AW'(i_ff + 8'd1);
         end
         ST_DJ: begin
            perm_rd_addr = SBOX_AW'(add_out);
         end
         ST_DWI: begin
            perm_we      = 1'b1;
            perm_wr_addr = SBOX_AW'(i_ff);
            perm_wr_data = perm_rd;
            perm_rd_addr = SBOX_AW'(t_sum);
         end
         ST_DWJ: begin
            perm_we      = 1'b1;
            perm_wr_addr = SBOX_AW'(j_ff);
         end
         ST_KJ: begin
            perm_rd_addr = SBOX_AW'(add_out);
         end
         ST_KWN: begin
            perm_we      = 1'b1;
            perm_wr_data = perm_rd;
         end
         ST_KWJ: begin
            perm_we      = 1'b1;
            perm_wr_addr = SBOX_AW'(j_ff);
         end
         default: begin
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      pass_in      = pass_ff;
      key_count_in = key_count_ff;
      key_len_in   = key_len_ff;
      sched_in     = sched_ff;
      passes_in    = csr_wr_en ? csr_wr_data : passes_ff;
      ks_in        = ks_ff;
      msg_in       = msg_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_INIT: begin
            n_in = n_ff + 1'b1;
            i_in = '0;
            j_in = '0;
            k_in = '0;
            pass_in = '0;
            if (n_ff == SBOX_AW'(SBOX_DEPTH - 1)) begin
               sched_in = 1'b0;
               if (sched_ff && (key_len_ff != '0) && (passes_ff != '0)) begin
                  state_in = ST_KRD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_payload.cmd == CMD_KEY) begin
                  if (key_we) begin
                     key_count_in = key_count_ff + 1'b1;
                  end
                  if (req_payload.last) begin
                     // new key complete: rebuild the sbox and, unless schedule_passes is zero, schedule it
                     key_len_in   = key_we ? (key_count_ff + 1'b1) : key_count_ff;
                     key_count_in = '0;
                     sched_in     = 1'b1;
                     n_in         = '0;
                     state_in     = ST_INIT;
                  end
               end else begin
                  i_in     = i_ff + 8'd1;
                  msg_in   = req_payload.in_byte;
                  last_in  = req_payload.last;
                  state_in = ST_DJ;
               end
            end
         end
         ST_DJ: begin
            j_in     = add_out;
            si_in    = perm_rd;
            state_in = ST_DWI;
         end
         ST_DWI: begin
            sj_in    = perm_rd;
            t_in     = t_sum;
            state_in = ST_DWJ;
         end
         ST_DWJ: begin
            // forward the swapped entries, the ram read saw the old table
            if (t_ff == j_ff) begin
               ks_in = si_ff;
            end else if (t_ff == i_ff) begin
               ks_in = sj_ff;
            end else begin
               ks_in = perm_rd;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_byte = msg_ff ^ ks_ff;
               rsp_data_in.out_last = last_ff;
               state_in             = ST_IDLE;
            end
         end
         ST_KRD: begin
            state_in = ST_KJ;
         end
         ST_KJ: begin
            j_in     = add_out;
            si_in    = perm_rd;
            state_in = ST_KWN;
         end
         ST_KWN: begin
            state_in = ST_KWJ;
         end
         ST_KWJ: begin
            n_in     = n_ff + 1'b1;
            k_in     = (k_next >= key_len_ff) ? '0 : KEY_IDX_W'(k_next);
            state_in = ST_KRD;
            if (n_ff == SBOX_AW'(SBOX_DEPTH - 1)) begin
               k_in    = '0;
               pass_in = pass_ff + 1'b1;
               if ((pass_ff + 1'b1) == passes_ff) begin
                  // schedule j is not carried into the keystream
                  j_in     = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         pass_ff      <= '0;
         key_count_ff <= '0;
         key_len_ff   <= '0;
         sched_ff     <= 1'b0;
         passes_ff    <= PASSES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         pass_ff      <= pass_in;
         key_count_ff <= key_count_in;
         key_len_ff   <= key_len_in;
         sched_ff     <= sched_in;
         passes_ff    <= passes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      ks_ff       <= ks_in;
      msg_ff      <= msg_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `RC4_ASSERT_IMPL(a_rsp_from_emit, $rose(rsp_valid_ff), $past(state_ff == ST_EMIT),
      "result appeared outside the emit step")
   `RC4_ASSERT_NEXT(a_last_key_sweeps,
      req_xfer && (req_payload.cmd == CMD_KEY) && req_payload.last,
      (state_ff == ST_INIT) && sched_ff && (key_count_ff == '0),
      "last key byte did not start the schedule")
   `RC4_ASSERT_IMPL(a_i_moves_on_data, !$stable(i_ff),
      $past(reset) || $past(state_ff == ST_INIT) ||
      $past(req_xfer && (req_payload.cmd == CMD_DATA)),
      "index i changed without a data transfer")
   `RC4_ASSERT_IMPL(a_key_count_bound, 1'b1,
      (key_count_ff <= KEY_CNT_W'(KEY_BYTES_MAX)) && (key_len_ff <= KEY_CNT_W'(KEY_BYTES_MAX)),
      "key count beyond key store depth")

endmodule
